FILE: rtl/assert_macros.svh
// Assertion helper macros for the barometer compensation RTL.
// Used by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high
`define BSCU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked property that also holds across reset
`define BSCU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bscu_pkg.sv
// Shared widths, latencies and register codes for the barometer compensation unit.
// No dependencies; used by bscu_mul and the top level.
package bscu_pkg;

  // Coefficient register indexes
  typedef enum logic [1:0] {
    CFG_TEMP  = 2'd0,
    CFG_PSENS = 2'd1,
    CFG_POFF  = 2'd2,
    CFG_PNL   = 2'd3
  } cfg_idx_t;

  // Datapath widths (signed)
  localparam int TN_W = 61;   // temperature numerator over 2^48
  localparam int A3_W = 34;   // p8*2^22 + p4*u
  localparam int C2_W = 34;   // p7*2^24 + p3*u
  localparam int E1_W = 61;   // first-order offset group over 2^85
  localparam int E0_W = 88;   // constant group over 2^116
  localparam int B2_W = 93;
  localparam int B1_W = 153;
  localparam int N_W  = 214;  // pressure numerator over 2^181

  // Multiplier latency: magnitude stage, one stage per 32-bit chunk, sign stage
  localparam int M3_LAT = (A3_W + 31) / 32 + 2;
  localparam int M2_LAT = (B2_W + 31) / 32 + 2;
  localparam int M1_LAT = (B1_W + 31) / 32 + 2;

  // Pipeline positions
  localparam int S_TN   = 5;
  localparam int S_MUL3 = 6;
  localparam int S_MUL2 = S_MUL3 + M3_LAT;
  localparam int S_MUL1 = S_MUL2 + M2_LAT;
  localparam int S_SUM  = S_MUL1 + M1_LAT;
  localparam int S_OUT  = S_SUM + 1;

  localparam int PRESS_LSB = 173;
  localparam int PRESS_W   = 25;

endpackage

FILE: rtl/bscu_mul.sv
// Pipelined signed multiplier: 61-bit temperature term times a BW-bit operand.
// Built from 32x32 partial products, one operand chunk per stage. Uses bscu_pkg.
module bscu_mul #(
  parameter int BW = bscu_pkg::A3_W
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [bscu_pkg::TN_W-1:0]  a,
  input  logic signed [BW-1:0]              b,
  output logic signed [bscu_pkg::TN_W+BW-1:0] p
);

  localparam int AW = bscu_pkg::TN_W;
  localparam int NC = (BW + 31) / 32;
  localparam int BP = NC * 32;
  localparam int PW = 64 + BP;
  localparam int OW = AW + BW;

  logic [63:0]   amag_q [0:NC-1];
  logic [BP-1:0] bmag_q [0:NC-1];
  logic          sgn_q  [0:NC];
  logic [PW-1:0] acc_q  [1:NC];

  // Sign/magnitude split
  always_ff @(posedge clk) begin
    if (en) begin
      amag_q[0] <= 64'($unsigned(a[AW-1] ? -a : a));
      bmag_q[0] <= BP'($unsigned(b[BW-1] ? -b : b));
      sgn_q[0]  <= a[AW-1] ^ b[BW-1];
    end
  end

  // One chunk of b per stage
  for (genvar k = 0; k < NC; k++) begin : g_stage
    logic [PW-1:0] acc_prev;
    logic [31:0]   bch;
    logic [63:0]   plo;
    logic [63:0]   phi;

    if (k == 0) begin : g_first
      assign acc_prev = '0;
    end else begin : g_rest
      assign acc_prev = acc_q[k];
    end

    assign bch = bmag_q[k][32*k +: 32];
    assign plo = 64'(amag_q[k][31:0]) * 64'(bch);
    assign phi = 64'(amag_q[k][63:32]) * 64'(bch);

    always_ff @(posedge clk) begin
      if (en) begin
        acc_q[k+1] <= acc_prev + (PW'(plo) << (32 * k)) + (PW'(phi) << (32 * k + 32));
        sgn_q[k+1] <= sgn_q[k];
      end
    end

    if (k < NC - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          amag_q[k+1] <= amag_q[k];
          bmag_q[k+1] <= bmag_q[k];
        end
      end
    end
  end

  // Reapply sign
  always_ff @(posedge clk) begin
    if (en) begin
      p <= OW'(sgn_q[NC] ? -$signed({1'b0, acc_q[NC]}) : $signed({1'b0, acc_q[NC]}));
    end
  end

endmodule

FILE: rtl/baro_sensor_compensation_unit.sv
// Top level: barometer temperature/pressure compensation pipeline.
// Depends on bscu_pkg, bscu_mul and assert_macros.svh.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  input   | in_valid, in_ready, raw_pressure, raw_temperature | in
//  output  | out_valid, out_ready, temperature_q16, ... | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
// One sample pair per cycle while the output is not stalled.
// The back end is a Horner chain of three wide multipliers (4, 5, 7 stages).
// A full output register with out_ready low freezes the whole pipeline.
// Synchronous reset clears the valid bits and the coefficient registers.
// Config writes are always taken (cfg_ready tied high).
`include "assert_macros.svh"

module baro_sensor_compensation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        raw_pressure,
  input  logic [23:0]        raw_temperature,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] temperature_q16,
  output logic [24:0]        pressure_q8,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int TN_W   = bscu_pkg::TN_W;
  localparam int A3_W   = bscu_pkg::A3_W;
  localparam int C2_W   = bscu_pkg::C2_W;
  localparam int E1_W   = bscu_pkg::E1_W;
  localparam int E0_W   = bscu_pkg::E0_W;
  localparam int B2_W   = bscu_pkg::B2_W;
  localparam int B1_W   = bscu_pkg::B1_W;
  localparam int N_W    = bscu_pkg::N_W;
  localparam int S_TN   = bscu_pkg::S_TN;
  localparam int S_MUL3 = bscu_pkg::S_MUL3;
  localparam int S_MUL2 = bscu_pkg::S_MUL2;
  localparam int S_MUL1 = bscu_pkg::S_MUL1;
  localparam int S_SUM  = bscu_pkg::S_SUM;
  localparam int S_OUT  = bscu_pkg::S_OUT;
  localparam int PLSB   = bscu_pkg::PRESS_LSB;
  localparam int PW     = bscu_pkg::PRESS_W;

  // Coefficient registers
  logic [39:0] temp_coef;
  logic [47:0] psens_coef;
  logic [47:0] poff_coef;
  logic [31:0] pnl_coef;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coef  <= '0;
      psens_coef <= '0;
      poff_coef  <= '0;
      pnl_coef   <= '0;
    end else if (cfg_valid) begin
      case (bscu_pkg::cfg_idx_t'(cfg_index))
        bscu_pkg::CFG_TEMP:  temp_coef  <= cfg_data[39:0];
        bscu_pkg::CFG_PSENS: psens_coef <= cfg_data;
        bscu_pkg::CFG_POFF:  poff_coef  <= cfg_data;
        bscu_pkg::CFG_PNL:   pnl_coef   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Coefficient fields
  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;
  logic signed [16:0] p1m, p2m;

  assign t1  = temp_coef[39:24];
  assign t2  = temp_coef[23:8];
  assign t3  = $signed(temp_coef[7:0]);
  assign p1  = $signed(psens_coef[47:32]);
  assign p2  = $signed(psens_coef[31:16]);
  assign p3  = $signed(psens_coef[15:8]);
  assign p4  = $signed(psens_coef[7:0]);
  assign p5  = poff_coef[47:32];
  assign p6  = poff_coef[31:16];
  assign p7  = $signed(poff_coef[15:8]);
  assign p8  = $signed(poff_coef[7:0]);
  assign p9  = $signed(pnl_coef[31:16]);
  assign p10 = $signed(pnl_coef[15:8]);
  assign p11 = $signed(pnl_coef[7:0]);
  assign p1m = 17'(p1) - 17'sd16384;
  assign p2m = 17'(p2) - 17'sd16384;

  // Pipeline control: everything advances together
  logic             en;
  logic [S_OUT:1]   vld;

  assign en        = !vld[S_OUT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S_OUT-1:1], in_valid};
    end
  end

  // Front stages: temperature numerator and powers of u
  logic [23:0]        up_s1, rt_s1;
  logic signed [25:0] d_s2;
  logic [23:0]        up_s2, up_s3, up_s4;
  logic signed [42:0] dt2_s3, dt2_s4;
  logic signed [51:0] dd_s3;
  logic [47:0]        usq_s3, usq_s4;
  logic signed [59:0] ddt3_s4;
  logic [71:0]        ucb_s4;
  logic signed [32:0] pu4_s5, pu3_s5;
  logic signed [41:0] pu2_s5, pu1_s5;
  logic signed [56:0] pu10_s5;
  logic signed [64:0] pu9_s5;
  logic signed [80:0] pu11_s5;
  logic signed [A3_W-1:0] a3_s6;

  logic signed [TN_W-1:0] tn_p [S_TN:S_MUL1];
  logic signed [C2_W-1:0] c2_p [S_MUL3:S_MUL2];
  logic signed [E1_W-1:0] e1_p [S_MUL3:S_MUL1];
  logic signed [E0_W-1:0] e0_p [S_MUL3:S_SUM];
  logic signed [23:0]     tq_p [S_MUL3:S_OUT];

  // Rounded, saturated temperature from the numerator
  logic signed [TN_W:0] tsum, tsh;
  logic signed [23:0]   tq;

  always_comb begin
    tsum = (TN_W+1)'(tn_p[S_TN]) + ((TN_W+1)'(1) <<< 31);
    tsh  = tsum >>> 32;
    if (tsh > (TN_W+1)'(8388607)) begin
      tq = 24'sh7FFFFF;
    end else if (tsh < -(TN_W+1)'(8388608)) begin
      tq = 24'sh800000;
    end else begin
      tq = tsh[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      up_s1   <= raw_pressure;
      rt_s1   <= raw_temperature;
      // stage 2
      d_s2    <= $signed({2'b00, rt_s1}) - $signed({2'b00, t1, 8'h00});
      up_s2   <= up_s1;
      // stage 3
      dt2_s3  <= 43'(d_s2) * 43'($signed({1'b0, t2}));
      dd_s3   <= 52'(d_s2) * 52'(d_s2);
      usq_s3  <= 48'(up_s2) * 48'(up_s2);
      up_s3   <= up_s2;
      // stage 4
      dt2_s4  <= dt2_s3;
      ddt3_s4 <= 60'(dd_s3) * 60'(t3);
      ucb_s4  <= 72'(usq_s3) * 72'(up_s3);
      usq_s4  <= usq_s3;
      up_s4   <= up_s3;
      // stage 5: numerator and coefficient products
      tn_p[S_TN] <= TN_W'($signed({dt2_s4, 18'b0})) + TN_W'(ddt3_s4);
      pu4_s5  <= 33'(p4) * 33'($signed({1'b0, up_s4}));
      pu3_s5  <= 33'(p3) * 33'($signed({1'b0, up_s4}));
      pu2_s5  <= 42'(p2m) * 42'($signed({1'b0, up_s4}));
      pu1_s5  <= 42'(p1m) * 42'($signed({1'b0, up_s4}));
      pu10_s5 <= 57'(p10) * 57'($signed({1'b0, usq_s4}));
      pu9_s5  <= 65'(p9) * 65'($signed({1'b0, usq_s4}));
      pu11_s5 <= 81'(p11) * 81'($signed({1'b0, ucb_s4}));
      // stage 6: coefficient groups
      a3_s6 <= (A3_W'(p8) <<< 22) + A3_W'(pu4_s5);
      c2_p[S_MUL3] <= (C2_W'(p7) <<< 24) + C2_W'(pu3_s5);
      e1_p[S_MUL3] <= (E1_W'($signed({1'b0, p6})) <<< 42) + (E1_W'(pu2_s5) <<< 19)
                      + E1_W'(pu10_s5);
      e0_p[S_MUL3] <= (E0_W'($signed({1'b0, p5})) <<< 68) + (E0_W'(pu1_s5) <<< 45)
                      + (E0_W'(pu9_s5) <<< 17) + E0_W'(pu11_s5);
      tq_p[S_MUL3] <= tq;
      // delay lines
      for (int k = S_TN + 1; k <= S_MUL1; k++) tn_p[k] <= tn_p[k-1];
      for (int k = S_MUL3 + 1; k <= S_MUL2; k++) c2_p[k] <= c2_p[k-1];
      for (int k = S_MUL3 + 1; k <= S_MUL1; k++) e1_p[k] <= e1_p[k-1];
      for (int k = S_MUL3 + 1; k <= S_SUM; k++) e0_p[k] <= e0_p[k-1];
      for (int k = S_MUL3 + 1; k <= S_OUT; k++) tq_p[k] <= tq_p[k-1];
    end
  end

  // Horner chain in the temperature term
  logic signed [TN_W+A3_W-1:0] m3;
  logic signed [B2_W-1:0]      b2;
  logic signed [TN_W+B2_W-1:0] m2;
  logic signed [B1_W-1:0]      b1;
  logic signed [TN_W+B1_W-1:0] m1;

  bscu_mul #(.BW(A3_W)) u_mul3 (
    .clk (clk), .en (en), .a (tn_p[S_MUL3]), .b (a3_s6), .p (m3)
  );

  assign b2 = B2_W'(m3) + (B2_W'(c2_p[S_MUL2]) <<< 53);

  bscu_mul #(.BW(B2_W)) u_mul2 (
    .clk (clk), .en (en), .a (tn_p[S_MUL2]), .b (b2), .p (m2)
  );

  assign b1 = B1_W'(m2) + (B1_W'(e1_p[S_MUL1]) <<< 85);

  bscu_mul #(.BW(B1_W)) u_mul1 (
    .clk (clk), .en (en), .a (tn_p[S_MUL1]), .b (b1), .p (m1)
  );

  // Final sum, rounding and saturation of pressure
  logic signed [N_W-1:0] nsum;
  logic [PW-1:0]         pq;

  always_comb begin
    nsum = N_W'(m1) + (N_W'(e0_p[S_SUM]) <<< 116) + (N_W'(1) <<< (PLSB - 1));
    if (nsum[N_W-1]) begin
      pq = '0;
    end else if (|nsum[N_W-2:PLSB+PW]) begin
      pq = '1;
    end else begin
      pq = nsum[PLSB+PW-1:PLSB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pressure_q8 <= pq;
    end
  end

  assign temperature_q16 = tq_p[S_OUT];

  // Checks
  `BSCU_ASSERT(a_stall_holds, clk, rst, !en |=> $stable(vld), "pipeline moved while stalled")
  `BSCU_ASSERT(a_entry, clk, rst, in_valid && in_ready |=> vld[1], "accepted sample not captured")
  `BSCU_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> (vld == '0), "valid bits survive reset")

endmodule
